[hw/rtl/imm_pkg.sv]
// Shared types, constants and helper functions for the integer matrix multiply block.
// Used by imm_mac and integer_matrix_multiply_top; depends on nothing else.
`default_nettype none

package imm_pkg;

	localparam int MaxDim     = 8;
	localparam int IdxW       = $clog2(MaxDim);
	localparam int DimW       = 4;
	localparam int StoreDepth = MaxDim * MaxDim;
	localparam int AddrW      = $clog2(StoreDepth);
	localparam int ElemW      = 64;
	localparam int HalfW      = ElemW / 2;
	localparam int TypeW      = 3;
	localparam int CmdW       = 2;
	localparam int CfgIdxW    = 2;

	localparam logic [CmdW-1:0] CMD_LOAD_A  = 2'd0;
	localparam logic [CmdW-1:0] CMD_LOAD_B  = 2'd1;
	localparam logic [CmdW-1:0] CMD_COMPUTE = 2'd2;

	localparam logic [CfgIdxW-1:0] CFG_ROWS_M    = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_INNER_K   = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_COLS_N    = 2'd2;
	localparam logic [CfgIdxW-1:0] CFG_ELEM_TYPE = 2'd3;

	localparam logic [DimW-1:0]  DIM_RESET  = 4'd8;
	localparam logic [TypeW-1:0] TYPE_RESET = 3'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MAC,
		ST_WAIT,
		ST_FIN
	} imm_state_t;

	typedef struct packed {
		logic start;
		logic first;
	} imm_mac_ctl_t;

	function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
		logic [DimW-1:0] r;
		r = v;
		if (v == '0) begin
			r = DimW'(1);
		end else if (v > DimW'(MaxDim)) begin
			r = DimW'(MaxDim);
		end
		return r;
	endfunction

	function automatic logic [ElemW-1:0] wrap_extend(input logic [ElemW-1:0] v,
			input logic [TypeW-1:0] t);
		logic [ElemW-1:0] r;
		logic ext;
		ext = 1'b0;
		r = v;
		case (t[1:0])
			2'd0: begin
				ext = ~t[2] & v[7];
				r = {{(ElemW-8){ext}}, v[7:0]};
			end
			2'd1: begin
				ext = ~t[2] & v[15];
				r = {{(ElemW-16){ext}}, v[15:0]};
			end
			2'd2: begin
				ext = ~t[2] & v[31];
				r = {{(ElemW-32){ext}}, v[31:0]};
			end
			default: begin
				r = v;
			end
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/imm_mac.sv]
// Multiply-accumulate unit: one shared 32x32 multiplier forms the low 64 bits of a
// 64x64 product in three passes and adds them into a wrapping accumulator. Uses imm_pkg.
`default_nettype none

module imm_mac (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire imm_pkg::imm_mac_ctl_t        ctl,
	input  wire logic [imm_pkg::ElemW-1:0]    a,
	input  wire logic [imm_pkg::ElemW-1:0]    b,
	output logic                              done,
	output logic [imm_pkg::ElemW-1:0]         acc
);

	logic [imm_pkg::ElemW-1:0] a_q;
	logic [imm_pkg::ElemW-1:0] b_q;
	logic [imm_pkg::ElemW-1:0] prod_q;
	logic [imm_pkg::ElemW-1:0] acc_q;
	logic [1:0]                ph_q;
	logic                      run_q;
	logic [imm_pkg::HalfW-1:0] op_a;
	logic [imm_pkg::HalfW-1:0] op_b;
	logic [imm_pkg::ElemW-1:0] mul_res;
	logic [imm_pkg::ElemW-1:0] addend;

	// Pass 0 forms the low by low product, passes 1 and 2 the two cross terms.
	always_comb begin
		op_a = a_q[imm_pkg::HalfW-1:0];
		op_b = b_q[imm_pkg::HalfW-1:0];
		if (ph_q == 2'd1) begin
			op_a = a_q[imm_pkg::ElemW-1:imm_pkg::HalfW];
		end else if (ph_q == 2'd2) begin
			op_b = b_q[imm_pkg::ElemW-1:imm_pkg::HalfW];
		end
		mul_res = op_a * op_b;
		if (ph_q == 2'd1) begin
			addend = prod_q;
		end else begin
			addend = {prod_q[imm_pkg::HalfW-1:0], {imm_pkg::HalfW{1'b0}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			ph_q  <= 2'd0;
		end else if (ctl.start) begin
			run_q <= 1'b1;
			ph_q  <= 2'd0;
		end else if (run_q) begin
			ph_q <= ph_q + 2'd1;
			if (ph_q == 2'd3) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			a_q <= a;
			b_q <= b;
			if (ctl.first) begin
				acc_q <= '0;
			end
		end else if (run_q) begin
			prod_q <= mul_res;
			if (ph_q != 2'd0) begin
				acc_q <= acc_q + addend;
			end
		end
	end

	assign done = run_q && (ph_q == 2'd3);
	assign acc  = acc_q;

endmodule

`default_nettype wire

[hw/rtl/integer_matrix_multiply_top.sv]
// Top level of the integer matrix multiply block: element stores, sequencer, output register.
// Depends on imm_pkg and imm_mac.
`default_nettype none

// Load items (cmd 0 for A, 1 for B) each write one 64-bit element and are accepted back to back while idle.
// A compute item (cmd 2) emits every element of C = A x B in row-major order, with last
// set on the final one; the input is stalled for the whole run. Each product term needs
// a store read, a start and the passes of the multiply-accumulate unit, whose single
// 32x32 multiplier makes three passes per 64-bit product. Each result element then waits
// until the output register can take it, so a stalled result side holds up the run.
// Dimensions and element type are sampled when the compute transfer happens.
module integer_matrix_multiply_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [imm_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [imm_pkg::DimW-1:0]      cfg_data,
	input  wire logic                          item_valid,
	output logic                               item_stall,
	input  wire logic [imm_pkg::CmdW-1:0]      cmd,
	input  wire logic [imm_pkg::IdxW-1:0]      row_index,
	input  wire logic [imm_pkg::IdxW-1:0]      col_index,
	input  wire logic signed [imm_pkg::ElemW-1:0] elem_value,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic signed [imm_pkg::ElemW-1:0]   result_value,
	output logic [imm_pkg::IdxW-1:0]           out_row,
	output logic [imm_pkg::IdxW-1:0]           out_col,
	output logic                               last
);

	logic [imm_pkg::DimW-1:0]  rows_m_q;
	logic [imm_pkg::DimW-1:0]  inner_k_q;
	logic [imm_pkg::DimW-1:0]  cols_n_q;
	logic [imm_pkg::TypeW-1:0] elem_type_q;

	logic [imm_pkg::DimW-1:0]  m_q;
	logic [imm_pkg::DimW-1:0]  k_q;
	logic [imm_pkg::DimW-1:0]  n_q;
	logic [imm_pkg::TypeW-1:0] type_q;

	logic [imm_pkg::IdxW-1:0]  i_q;
	logic [imm_pkg::IdxW-1:0]  j_q;
	logic [imm_pkg::IdxW-1:0]  t_q;

	imm_pkg::imm_state_t state_q;
	imm_pkg::imm_state_t state_d;

	logic [imm_pkg::ElemW-1:0] a_mem [imm_pkg::StoreDepth];
	logic [imm_pkg::ElemW-1:0] b_mem [imm_pkg::StoreDepth];
	logic [imm_pkg::ElemW-1:0] a_rd_q;
	logic [imm_pkg::ElemW-1:0] b_rd_q;
	logic [imm_pkg::AddrW-1:0] wr_addr;
	logic [imm_pkg::AddrW-1:0] a_rd_addr;
	logic [imm_pkg::AddrW-1:0] b_rd_addr;

	logic                      res_valid_q;
	logic [imm_pkg::ElemW-1:0] res_value_q;
	logic [imm_pkg::IdxW-1:0]  res_row_q;
	logic [imm_pkg::IdxW-1:0]  res_col_q;
	logic                      res_last_q;

	imm_pkg::imm_mac_ctl_t     mac_ctl;
	logic                      mac_done;
	logic [imm_pkg::ElemW-1:0] mac_acc;

	logic item_xfer;
	logic t_end;
	logic j_end;
	logic i_end;
	logic emit;

	assign cfg_ready  = 1'b1;
	assign item_stall = (state_q != imm_pkg::ST_IDLE);
	assign item_xfer  = item_valid && !item_stall;

	assign t_end = ({1'b0, t_q} == k_q - imm_pkg::DimW'(1));
	assign j_end = ({1'b0, j_q} == n_q - imm_pkg::DimW'(1));
	assign i_end = ({1'b0, i_q} == m_q - imm_pkg::DimW'(1));
	assign emit  = (state_q == imm_pkg::ST_FIN) && (!res_valid_q || !result_stall);

	assign wr_addr   = {row_index, col_index};
	assign a_rd_addr = {i_q, t_q};
	assign b_rd_addr = {t_q, j_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_m_q    <= imm_pkg::DIM_RESET;
			inner_k_q   <= imm_pkg::DIM_RESET;
			cols_n_q    <= imm_pkg::DIM_RESET;
			elem_type_q <= imm_pkg::TYPE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				imm_pkg::CFG_ROWS_M:    rows_m_q    <= cfg_data;
				imm_pkg::CFG_INNER_K:   inner_k_q   <= cfg_data;
				imm_pkg::CFG_COLS_N:    cols_n_q    <= cfg_data;
				imm_pkg::CFG_ELEM_TYPE: elem_type_q <= cfg_data[imm_pkg::TypeW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_xfer && cmd == imm_pkg::CMD_LOAD_A) begin
			a_mem[wr_addr] <= elem_value;
		end
		a_rd_q <= a_mem[a_rd_addr];
	end

	always_ff @(posedge clk) begin
		if (item_xfer && cmd == imm_pkg::CMD_LOAD_B) begin
			b_mem[wr_addr] <= elem_value;
		end
		b_rd_q <= b_mem[b_rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= imm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		mac_ctl.start = 1'b0;
		mac_ctl.first = (t_q == '0);
		case (state_q)
			imm_pkg::ST_IDLE: begin
				if (item_xfer && cmd == imm_pkg::CMD_COMPUTE) begin
					state_d = imm_pkg::ST_READ;
				end
			end
			imm_pkg::ST_READ: begin
				state_d = imm_pkg::ST_MAC;
			end
			imm_pkg::ST_MAC: begin
				mac_ctl.start = 1'b1;
				state_d = imm_pkg::ST_WAIT;
			end
			imm_pkg::ST_WAIT: begin
				if (mac_done) begin
					state_d = t_end ? imm_pkg::ST_FIN : imm_pkg::ST_READ;
				end
			end
			imm_pkg::ST_FIN: begin
				if (emit) begin
					state_d = (i_end && j_end) ? imm_pkg::ST_IDLE : imm_pkg::ST_READ;
				end
			end
			default: begin
				state_d = imm_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q    <= imm_pkg::DIM_RESET;
			k_q    <= imm_pkg::DIM_RESET;
			n_q    <= imm_pkg::DIM_RESET;
			type_q <= imm_pkg::TYPE_RESET;
			i_q    <= '0;
			j_q    <= '0;
			t_q    <= '0;
		end else begin
			if (state_q == imm_pkg::ST_IDLE && item_xfer && cmd == imm_pkg::CMD_COMPUTE) begin
				m_q    <= imm_pkg::clamp_dim(rows_m_q);
				k_q    <= imm_pkg::clamp_dim(inner_k_q);
				n_q    <= imm_pkg::clamp_dim(cols_n_q);
				type_q <= elem_type_q;
				i_q    <= '0;
				j_q    <= '0;
				t_q    <= '0;
			end else if (state_q == imm_pkg::ST_WAIT && mac_done && !t_end) begin
				t_q <= t_q + imm_pkg::IdxW'(1);
			end else if (emit) begin
				t_q <= '0;
				if (j_end) begin
					j_q <= '0;
					i_q <= i_q + imm_pkg::IdxW'(1);
				end else begin
					j_q <= j_q + imm_pkg::IdxW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_value_q <= imm_pkg::wrap_extend(mac_acc, type_q);
			res_row_q   <= i_q;
			res_col_q   <= j_q;
			res_last_q  <= i_end && j_end;
		end
	end

	imm_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a      (a_rd_q),
		.b      (b_rd_q),
		.done   (mac_done),
		.acc    (mac_acc)
	);

	assign result_valid = res_valid_q;
	assign result_value = res_value_q;
	assign out_row      = res_row_q;
	assign out_col      = res_col_q;
	assign last         = res_last_q;

endmodule

`default_nettype wire
